/* sv/random_page_replacement_macros.svh */
// Assertion macros used by the random page replacement RTL.
`ifndef RANDOM_PAGE_REPLACEMENT_MACROS_SVH
`define RANDOM_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define RPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rpr: check failed");

// Next-cycle implication, checked on i_clk outside reset.
`define RPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpr: check failed");

`endif

/* sv/rpr_pkg.sv */
// Shared constants, the state type and the LFSR step function of the random page replacement block.
package rpr_pkg;

    localparam int FRAMES    = 64;
    localparam int PAGE_BITS = 20;

    localparam int LIMIT_W   = 7;
    localparam int SEED_W    = 32;
    localparam int LFSR_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam int COUNT_W   = $clog2(FRAMES + 1);
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CMP_W     = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
    localparam int STEP_W    = $clog2(LFSR_W);

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD_VIC,
        ST_RD_LAST,
        ST_WR_SLOT,
        ST_WR_LAST,
        ST_OUT
    } t_state;

    // One right shift of the Galois LFSR.
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

/* sv/random_page_replacement.sv */
// Random page replacement: resident page store with LFSR victim choice.
// Fill fault (count below limit): the page is written at accept, and the result goes through ST_OUT.
// Eviction fault: the result follows the 32-step serial remainder and then two reads and
//   two writes through the page store.
// One item in work at a time; the output register lets a result wait while idle.
// Reset: count 0, frame limit 64, LFSR 1; the page store is not cleared.
module random_page_replacement
    import rpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PAGE_BITS-1:0] i_page_number,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_did_evict,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

`include "random_page_replacement_macros.svh"

    t_state r_state, n_state;

    logic [LIMIT_W-1:0]   r_frame_limit;
    logic [LFSR_W-1:0]    r_lfsr;
    logic [COUNT_W-1:0]   r_count;
    logic [PAGE_BITS-1:0] r_page;
    logic [IDX_W-1:0]     r_slot;
    logic                 r_res_evict;
    logic [PAGE_BITS-1:0] r_res_page;
    logic                 r_out_valid;
    logic                 r_did_evict;
    logic [PAGE_BITS-1:0] r_evicted_page;

    logic [PAGE_BITS-1:0] mem [FRAMES];
    logic [PAGE_BITS-1:0] r_rd_data;

    logic [CMP_W-1:0]     limit_ext;
    logic [COUNT_W-1:0]   eff_limit;
    logic                 in_acc;
    logic                 out_free;
    logic                 fill;
    logic [IDX_W-1:0]     last_idx;
    logic [LFSR_W-1:0]    lfsr_adv;
    logic [LFSR_W-1:0]    seed_in;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [PAGE_BITS-1:0] wr_data;
    logic [IDX_W-1:0]     rd_addr;
    logic                 div_start;
    logic                 div_done;
    logic [IDX_W-1:0]     div_rem;

    // Clamp the frame limit into one to FRAMES
    always_comb begin
        limit_ext = CMP_W'(r_frame_limit);
        if (limit_ext == '0) begin
            eff_limit = COUNT_W'(1);
        end else if (limit_ext > CMP_W'(FRAMES)) begin
            eff_limit = COUNT_W'(FRAMES);
        end else begin
            eff_limit = limit_ext[COUNT_W-1:0];
        end
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign fill     = r_count < eff_limit;
    assign last_idx = IDX_W'(r_count - 1'b1);
    assign lfsr_adv = lfsr_next(r_lfsr);
    assign seed_in  = i_cfg_data[SEED_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = fill ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_RD_VIC;
                end
            end
            ST_RD_VIC:  n_state = ST_RD_LAST;
            ST_RD_LAST: n_state = ST_WR_SLOT;
            ST_WR_SLOT: n_state = ST_WR_LAST;
            ST_WR_LAST: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory port, divider start and input stall
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_count[IDX_W-1:0];
        wr_data    = i_page_number;
        rd_addr    = r_slot;
        div_start  = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                wr_en      = i_in_valid && fill;
                div_start  = i_in_valid && !fill;
            end
            ST_RD_VIC:  rd_addr = r_slot;
            ST_RD_LAST: rd_addr = last_idx;
            ST_WR_SLOT: begin
                wr_en   = 1'b1;
                wr_addr = r_slot;
                wr_data = r_rd_data;
            end
            ST_WR_LAST: begin
                wr_en   = 1'b1;
                wr_addr = last_idx;
                wr_data = r_page;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Page store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Control registers, configuration and LFSR
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_frame_limit <= LIMIT_RESET;
            r_lfsr        <= LFSR_W'(1);
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == REG_FRAME_LIMIT) begin
                r_frame_limit <= i_cfg_data[LIMIT_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_RANDOM_SEED) begin
                r_lfsr <= (seed_in == '0) ? LFSR_W'(1) : LFSR_W'(seed_in);
            end else if (r_state == ST_IDLE && in_acc && !fill) begin
                r_lfsr <= lfsr_adv;
            end
            if (r_state == ST_IDLE && in_acc && fill) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the item in work and of the result
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_page      <= i_page_number;
            r_res_evict <= !fill;
            r_res_page  <= '0;
        end
        if (r_state == ST_DIV && div_done) begin
            r_slot <= div_rem;
        end
        if (r_state == ST_RD_LAST) begin
            r_res_page <= r_rd_data;
        end
        if (r_state == ST_OUT && out_free) begin
            r_did_evict    <= r_res_evict;
            r_evicted_page <= r_res_page;
        end
    end

    // Victim slot: advanced LFSR value modulo the count
    rpr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (lfsr_adv),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_out_valid    = r_out_valid;
    assign o_did_evict    = r_did_evict;
    assign o_evicted_page = r_evicted_page;

    `RPR_ASSERT_NOW(a_count_bound, 1'b1, r_count <= COUNT_W'(FRAMES))
    `RPR_ASSERT_NOW(a_lfsr_live, 1'b1, r_lfsr != '0)
    `RPR_ASSERT_NEXT(a_fill_counts, in_acc && fill, r_count == $past(r_count) + 1'b1)
    `RPR_ASSERT_NOW(a_evict_needs_page, r_out_valid && r_did_evict, r_count != '0)
    `RPR_ASSERT_NOW(a_fill_zero_page, r_out_valid && !r_did_evict, r_evicted_page == '0)

endmodule

/* sv/rpr_mod.sv */
// Serial restoring remainder of the 32-bit random value by the frame count.
module rpr_mod
    import rpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [LFSR_W-1:0]  i_dividend,
    input  logic [COUNT_W-1:0] i_divisor,
    output logic               o_done,
    output logic [IDX_W-1:0]   o_rem
);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [LFSR_W-1:0]  r_dvd;
    logic [COUNT_W-1:0] r_div;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               fits;

    // Shift in one dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_dvd[LFSR_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = trial >= {1'b0, r_div};
    end

    // Control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(LFSR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end
    end

    // Datapath: partial remainder and dividend shift
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        end else if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[IDX_W-1:0];

endmodule

/* tb/tb_random_page_replacement.sv */
// Testbench for the random page replacement block: self-checking fault stream.
`timescale 1ns / 100ps

module tb_random_page_replacement
    import rpr_pkg::*;
();

    // Unused register indexes, written to check that the block ignores them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [PAGE_BITS-1:0] PAGE_ALL_ONES = '1;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic                 did_evict;
        logic [PAGE_BITS-1:0] evicted_page;
    } t_fault_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [PAGE_BITS-1:0] i_page_number = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_did_evict;
    logic [PAGE_BITS-1:0] o_evicted_page;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    // Predictor state
    logic [PAGE_BITS-1:0] resident_pages [FRAMES];
    int unsigned          pages_resident = 0;
    logic [LIMIT_W-1:0]   frame_limit_shadow = 7'd64;
    logic [LFSR_W-1:0]    victim_lfsr_shadow = 32'd1;

    t_fault_result fault_results_due [$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            tx_idle_pct = 37;
    int            rx_idle_pct = 37;
    int            hold_off_left = 0;

    random_page_replacement dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_page_number  (i_page_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_did_evict    (o_did_evict),
        .o_evicted_page (o_evicted_page),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Galois LFSR step: shift right, fold in the taps when a one drops out
    function automatic logic [LFSR_W-1:0] step_victim_lfsr(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] nxt;
        nxt = v >> 1;
        if (v[0]) begin
            nxt = nxt ^ 32'h8020_0003;
        end
        return nxt;
    endfunction

    // Predict the result of one accepted fault and update the shadow store
    task automatic predict_fault(input logic [PAGE_BITS-1:0] page);
        int unsigned   lim;
        int unsigned   slot;
        int unsigned   last;
        t_fault_result res;
        lim = 32'(frame_limit_shadow);
        if (lim == 0) begin
            lim = 1;
        end
        if (lim > FRAMES) begin
            lim = FRAMES;
        end
        res = '0;
        if (pages_resident < lim) begin
            resident_pages[pages_resident] = page;
            pages_resident++;
        end else begin
            last = pages_resident - 1;
            victim_lfsr_shadow = step_victim_lfsr(victim_lfsr_shadow);
            slot = victim_lfsr_shadow % pages_resident;
            res.did_evict = 1'b1;
            res.evicted_page = resident_pages[slot];
            resident_pages[slot] = resident_pages[last];
            resident_pages[last] = page;
        end
        fault_results_due.push_back(res);
    endtask

    // Offer one fault item, with random idle cycles ahead of it
    task automatic send_fault(input logic [PAGE_BITS-1:0] page);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_page_number <= page;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_fault(page);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (fault_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_LIMIT: frame_limit_shadow = data[LIMIT_W-1:0];
            REG_RANDOM_SEED: victim_lfsr_shadow = (data == 0) ? 32'd1 : data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send a run of random faults, with the page extremes mixed in
    task automatic send_fault_burst(input int count);
        logic [PAGE_BITS-1:0] page;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(15))
                0: page = '0;
                1: page = PAGE_ALL_ONES;
                default: page = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
            endcase
            send_fault(page);
        end
    endtask

    // Limit zero acts as one frame: fill once, then every fault evicts
    task automatic test_minimum_frame_limit();
        write_reg(REG_FRAME_LIMIT, 32'd0);
        send_fault('0);
        send_fault(PAGE_ALL_ONES);
        send_fault(20'hAAAAA);
        write_reg(REG_FRAME_LIMIT, 32'd1);
        send_fault(20'h55555);
    endtask

    // Raise the limit: fill up to it, then evict among the resident pages
    task automatic test_fill_and_evict();
        write_reg(REG_FRAME_LIMIT, 32'd4);
        send_fault(20'h00001);
        send_fault(20'h80000);
        send_fault(20'h12345);
        send_fault(20'hFEDCB);
        send_fault(20'h0F0F0);
    endtask

    // Seed writes reload the LFSR; zero must load one instead
    task automatic test_seed_reload();
        write_reg(REG_RANDOM_SEED, 32'd0);
        send_fault(20'h11111);
        send_fault(20'h22222);
        write_reg(REG_RANDOM_SEED, 32'hFFFF_FFFF);
        send_fault(20'h33333);
        send_fault(20'h44444);
        write_reg(REG_RANDOM_SEED, 32'h8000_0000);
        send_fault(20'h66666);
    endtask

    // Writes to unused indexes change nothing
    task automatic test_unknown_register();
        write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_3, 32'h0000_0000);
        send_fault(20'h77777);
        send_fault(20'h88888);
    endtask

    // Limit above the store depth saturates: fill all frames, then evict
    task automatic test_saturated_limit();
        write_reg(REG_FRAME_LIMIT, 32'd127);
        write_reg(REG_RANDOM_SEED, $urandom());
        send_fault_burst(250);
    endtask

    // Limit lowered below the count: keep the count, evict among all pages
    task automatic test_limit_below_count();
        write_reg(REG_FRAME_LIMIT, 32'd2);
        write_reg(REG_RANDOM_SEED, $urandom());
        send_fault_burst(150);
    endtask

    // Hold the output for a long stretch so the block stalls its input
    task automatic test_backpressure();
        write_reg(REG_FRAME_LIMIT, 32'd64);
        write_reg(REG_RANDOM_SEED, 32'hFFFF_FFFF);
        hold_off_left = 500;
        send_fault_burst(100);
    endtask

    // Run both sides without idle cycles
    task automatic test_no_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_fault_burst(150);
        tx_idle_pct = 37;
        rx_idle_pct = 37;
    endtask

    // Random settings, with junk in the unused upper bits of the limit
    task automatic test_random_settings();
        logic [CFG_DAT_W-1:0] seed;
        for (int k = 0; k < 5; k++) begin
            seed = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
            write_reg(REG_FRAME_LIMIT,
                      {(CFG_DAT_W - LIMIT_W)'($urandom_range(0,
                                                (1 << (CFG_DAT_W - LIMIT_W)) - 1)),
                       LIMIT_W'($urandom_range(0, 127))});
            write_reg(REG_RANDOM_SEED, seed);
            send_fault_burst(60);
        end
    endtask

    // Check accepted results and drive the output stall
    always @(posedge i_clk) begin
        t_fault_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fault_results_due.size() == 0) begin
                error_count++;
                if (error_count <= MAX_SHOWN) begin
                    $display("result with nothing expected: did_evict=%0b evicted_page=%05h",
                             o_did_evict, o_evicted_page);
                end
            end else begin
                want = fault_results_due.pop_front();
                if (o_did_evict !== want.did_evict || o_evicted_page !== want.evicted_page) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN) begin
                        $display("mismatch: did_evict exp %0b got %0b, evicted_page exp %05h got %05h",
                                 want.did_evict, o_did_evict, want.evicted_page, o_evicted_page);
                    end
                end
            end
        end
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_minimum_frame_limit();
        test_fill_and_evict();
        test_seed_reload();
        test_unknown_register();
        test_saturated_limit();
        test_limit_below_count();
        test_backpressure();
        test_no_idle();
        test_random_settings();
        wait_idle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* random_page_replacement.f */
+incdir+sv
sv/rpr_pkg.sv
sv/rpr_mod.sv
sv/random_page_replacement.sv
tb/tb_random_page_replacement.sv
